// ===== sv/rm2q_pkg.sv =====
// shared types and codes for the rotation matrix to quaternion block
`default_nettype none
package rm2q_pkg;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    localparam int NUM_ELEMS = 9;
    localparam int NUM_COMPS = 4;
    localparam int NUM_OFF   = 3;

endpackage
`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Usage notes for the rotation matrix to quaternion converter.
//
// Slave stream: one request carries a 3x3 matrix, nine signed fixed-point elements in
// i_s_tdata. Master stream: one quaternion (w, x, y, z) in o_m_tdata, with the branch code
// and the degenerate flag in o_m_tuser.
// The datapath is a fully pipelined chain: one input stage (trace, branch, radicand and
// numerators), one stage per root bit of a restoring square root, one setup stage, one stage
// per quotient bit of three parallel restoring dividers, and one saturation stage.
// Elements and quaternion components use the Q2.14 format at the default parameters.
// Throughput is one matrix per cycle while the output is not stalled, set by the
// one-bit-per-stage root and divider chains.
// The whole pipe advances when the output register is empty or taken, so a stall of the
// receiver freezes every stage and holds o_m_tdata; nothing is dropped or repeated.
// Reset clears all valid bits; no result appears until new requests arrive.
`default_nettype none
module rotation_matrix_to_quaternion
    import rm2q_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14,
    localparam int IN_W  = ((NUM_ELEMS * ELEMENT_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_COMPS * ELEMENT_WIDTH + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // m00, m10, m20, m01, m11, m21, m02, m12, m22, zero fill
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    output logic [OUT_W-1:0]      o_m_tdata,
    // branch_taken[1:0], degenerate[2]
    output logic [2:0]            o_m_tuser
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int RW    = EW + 3;
    localparam int VW    = RW - 1 + FRACTION_BITS;
    localparam int SW    = (VW + 1) / 2;
    localparam int NW    = EW + 1;
    localparam int DW    = EW + FRACTION_BITS + 1;
    localparam int DEPTH = SW + DW + 3;
    localparam int ST_OUT  = DEPTH - 1;

    typedef struct packed {
        logic          ovf;
        logic [EW-1:0] val;
    } t_sat;

    localparam logic [DW-1:0] LIM_P = {{(DW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic [DW-1:0] LIM_N = LIM_P + 1'b1;

    function automatic t_sat sat_val(input logic [DW-1:0] q, input logic neg);
        t_sat          res;
        logic [DW-1:0] negq;
        negq = ~q + 1'b1;
        res.ovf = 1'b0;
        if (!neg) begin
            if (q > LIM_P) begin
                res.ovf = 1'b1;
                res.val = LIM_P[EW-1:0];
            end else begin
                res.val = q[EW-1:0];
            end
        end else begin
            if (q > LIM_N) begin
                res.ovf = 1'b1;
                res.val = LIM_N[EW-1:0];
            end else begin
                res.val = negq[EW-1:0];
            end
        end
        return res;
    endfunction

    logic r_vld [DEPTH];
    logic adv;

    assign adv        = !r_vld[ST_OUT] || i_m_tready;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // input stage: trace, branch select, radicand, numerators
    logic signed [EW-1:0] el [NUM_ELEMS];
    logic signed [RW-1:0] trace, rad, one;
    logic signed [NW-1:0] num [NUM_OFF];
    t_branch              br;

    always_comb begin
        for (int k = 0; k < NUM_ELEMS; k++) begin
            el[k] = i_s_tdata[k*EW +: EW];
        end
        one   = RW'(1) <<< FRACTION_BITS;
        trace = RW'(el[0]) + RW'(el[4]) + RW'(el[8]);
        priority if (trace > 0) begin
            br     = BR_TRACE;
            rad    = one + trace;
            num[0] = NW'(el[5]) - NW'(el[7]);
            num[1] = NW'(el[6]) - NW'(el[2]);
            num[2] = NW'(el[1]) - NW'(el[3]);
        end else if (el[0] > el[4] && el[0] > el[8]) begin
            br     = BR_X;
            rad    = one + RW'(el[0]) - RW'(el[4]) - RW'(el[8]);
            num[0] = NW'(el[5]) - NW'(el[7]);
            num[1] = NW'(el[3]) + NW'(el[1]);
            num[2] = NW'(el[6]) + NW'(el[2]);
        end else if (el[4] > el[8]) begin
            br     = BR_Y;
            rad    = one + RW'(el[4]) - RW'(el[0]) - RW'(el[8]);
            num[0] = NW'(el[6]) - NW'(el[2]);
            num[1] = NW'(el[3]) + NW'(el[1]);
            num[2] = NW'(el[7]) + NW'(el[5]);
        end else begin
            br     = BR_Z;
            rad    = one + RW'(el[8]) - RW'(el[0]) - RW'(el[4]);
            num[0] = NW'(el[1]) - NW'(el[3]);
            num[1] = NW'(el[6]) + NW'(el[2]);
            num[2] = NW'(el[7]) + NW'(el[5]);
        end
    end

    // square root stages, index k holds the state after k root bits
    logic [SW+1:0]   r_sq_rem  [SW+1];
    logic [SW-1:0]   r_sq_root [SW+1];
    logic [2*SW-1:0] r_sq_v    [SW+1];
    logic [NW-1:0]   r_sq_mag  [SW+1][NUM_OFF];
    logic            r_sq_neg  [SW+1][NUM_OFF];
    t_branch         r_sq_br   [SW+1];
    logic            r_sq_np   [SW+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_br[0]   <= br;
            r_sq_np[0]   <= (rad <= 0);
            if (rad <= 0) begin
                r_sq_v[0] <= '0;
            end else begin
                r_sq_v[0] <= (2*SW)'(rad[RW-2:0]) << FRACTION_BITS;
            end
            for (int j = 0; j < NUM_OFF; j++) begin
                r_sq_neg[0][j] <= num[j][NW-1];
                r_sq_mag[0][j] <= num[j][NW-1] ? (~num[j] + 1'b1) : num[j];
            end
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [SW+3:0] t, trial;
        logic          take;
        assign t     = {r_sq_rem[k], r_sq_v[k][2*SW-1 -: 2]};
        assign trial = {2'b00, r_sq_root[k], 2'b01};
        assign take  = (t >= trial);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[k+1]  <= take ? (SW+2)'(t - trial) : t[SW+1:0];
                r_sq_root[k+1] <= {r_sq_root[k][SW-2:0], take};
                r_sq_v[k+1]    <= r_sq_v[k] << 2;
                r_sq_mag[k+1]  <= r_sq_mag[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_br[k+1]   <= r_sq_br[k];
                r_sq_np[k+1]   <= r_sq_np[k];
            end
        end
    end

    // divider stages, quotient bits shift in at the bottom of the dividend word
    logic [SW-1:0] r_dv_rem  [DW+1][NUM_OFF];
    logic [DW-1:0] r_dv_dq   [DW+1][NUM_OFF];
    logic          r_dv_neg  [DW+1][NUM_OFF];
    logic [SW-1:0] r_dv_h    [DW+1];
    logic [SW-1:0] r_dv_diag [DW+1];
    t_branch       r_dv_br   [DW+1];
    logic          r_dv_np   [DW+1];

    logic [SW:0] h_inc;
    assign h_inc = {1'b0, r_sq_root[SW]} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_h[0]    <= r_sq_root[SW];
            r_dv_diag[0] <= h_inc[SW:1];
            r_dv_br[0]   <= r_sq_br[SW];
            r_dv_np[0]   <= r_sq_np[SW];
            for (int j = 0; j < NUM_OFF; j++) begin
                r_dv_rem[0][j] <= '0;
                r_dv_neg[0][j] <= r_sq_neg[SW][j];
                r_dv_dq[0][j]  <= (DW'(r_sq_mag[SW][j]) << (FRACTION_BITS - 1))
                                  + DW'(r_sq_root[SW][SW-1:1]);
            end
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        for (genvar j = 0; j < NUM_OFF; j++) begin : g_lane
            logic [SW:0] t;
            logic        take;
            assign t    = {r_dv_rem[k][j], r_dv_dq[k][j][DW-1]};
            assign take = (t >= {1'b0, r_dv_h[k]});
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_rem[k+1][j] <= take ? SW'(t - {1'b0, r_dv_h[k]}) : t[SW-1:0];
                    r_dv_dq[k+1][j]  <= {r_dv_dq[k][j][DW-2:0], take};
                    r_dv_neg[k+1][j] <= r_dv_neg[k][j];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_h[k+1]    <= r_dv_h[k];
                r_dv_diag[k+1] <= r_dv_diag[k];
                r_dv_br[k+1]   <= r_dv_br[k];
                r_dv_np[k+1]   <= r_dv_np[k];
            end
        end
    end

    // output stage: saturate and place components by branch
    t_sat                 s_off [NUM_OFF];
    t_sat                 s_diag;
    logic [EW-1:0]        comp  [NUM_COMPS];
    logic                 ovf;
    logic [1:0]           br_code;
    logic [OUT_W-1:0]     out_data;
    logic [OUT_W-1:0]     r_out_data;
    logic [2:0]           r_out_user;

    always_comb begin
        for (int j = 0; j < NUM_OFF; j++) begin
            s_off[j] = sat_val(r_dv_dq[DW][j], r_dv_neg[DW][j]);
        end
        s_diag  = sat_val(DW'(r_dv_diag[DW]), 1'b0);
        br_code = r_dv_br[DW];
        ovf     = s_diag.ovf | s_off[0].ovf | s_off[1].ovf | s_off[2].ovf;
        for (int p = 0; p < NUM_COMPS; p++) begin
            if (r_dv_np[DW]) begin
                comp[p] = '0;
            end else if (p == int'(br_code)) begin
                comp[p] = s_diag.val;
            end else if (p < int'(br_code)) begin
                comp[p] = s_off[(p < NUM_OFF) ? p : NUM_OFF - 1].val;
            end else begin
                comp[p] = s_off[(p > 0) ? p - 1 : 0].val;
            end
        end
        out_data = '0;
        for (int p = 0; p < NUM_COMPS; p++) begin
            out_data[p*EW +: EW] = comp[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= out_data;
            r_out_user <= {r_dv_np[DW] | ovf, br_code};
        end
    end

    assign o_m_tvalid = r_vld[ST_OUT];
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
`default_nettype wire

// ===== sv/rm2q_checker.sv =====
// port-level checks for the rotation matrix to quaternion block
`default_nettype none
module rm2q_checker
    import rm2q_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16,
    parameter int OUT_W = 64
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata,
    input wire logic [2:0]       o_m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result after reset");

    // input side moves only when the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output stall");

    // trace branch gives a non-negative scalar part
    a_wpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == BR_TRACE && !o_m_tuser[2]
            |-> !o_m_tdata[ELEMENT_WIDTH-1])
        else $error("negative scalar part in trace branch");

endmodule

bind rotation_matrix_to_quaternion rm2q_checker #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .OUT_W(OUT_W)
) u_rm2q_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser)
);
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
// testbench for the rotation matrix to quaternion block: directed and random matrices
`default_nettype none
module rotation_matrix_to_quaternion_tb;
    import rm2q_pkg::*;

    localparam int EW = 16;
    localparam int FB = 14;
    localparam int IN_W = ((NUM_ELEMS * EW + 7) / 8) * 8;
    localparam int OUT_W = ((NUM_COMPS * EW + 7) / 8) * 8;
    localparam int LATENCY = 50;
    localparam longint EMAX = (64'sd1 <<< (EW - 1)) - 1;
    localparam longint EMIN = -(64'sd1 <<< (EW - 1));

    typedef struct packed {
        logic [EW-1:0] w;
        logic [EW-1:0] x;
        logic [EW-1:0] y;
        logic [EW-1:0] z;
        t_branch       br;
        logic          deg;
    } t_quat;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             i_m_tready = 1'b0;
    wire              o_s_tready;
    wire              o_m_tvalid;
    wire [OUT_W-1:0]  o_m_tdata;
    wire [2:0]        o_m_tuser;

    t_quat  quat_expected[$];
    int     mismatches = 0;
    bit     calm = 1'b0;    // no idling on either side
    longint mat[9];

    rotation_matrix_to_quaternion i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint isqrt(longint v);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // n/(2h), rounded half away from zero
    function automatic longint half_ratio(longint n, longint h);
        longint mag = (n < 0) ? -n : n;
        longint q = ((mag <<< (FB - 1)) + (h >>> 1)) / h;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [EW-1:0] clamp(longint v, ref logic deg);
        if (v > EMAX) begin
            deg = 1'b1;
            v = EMAX;
        end else if (v < EMIN) begin
            deg = 1'b1;
            v = EMIN;
        end
        return v[EW-1:0];
    endfunction

    // element order m00 m10 m20 m01 m11 m21 m02 m12 m22
    function automatic t_quat quat_from_matrix(longint m[9]);
        t_quat  res;
        longint q[4] = '{0, 0, 0, 0};
        longint tr = m[0] + m[4] + m[8];
        longint rad;
        longint h;
        longint dg;
        logic   deg = 1'b0;
        if (tr > 0) begin
            res.br = BR_TRACE;
            rad = (64'sd1 <<< FB) + tr;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            res.br = BR_X;
            rad = (64'sd1 <<< FB) + m[0] - m[4] - m[8];
        end else if (m[4] > m[8]) begin
            res.br = BR_Y;
            rad = (64'sd1 <<< FB) + m[4] - m[0] - m[8];
        end else begin
            res.br = BR_Z;
            rad = (64'sd1 <<< FB) + m[8] - m[0] - m[4];
        end
        if (rad <= 0) begin
            deg = 1'b1;
        end else begin
            h = isqrt(rad <<< FB);
            dg = (h + 1) >>> 1;
            case (res.br)
                BR_TRACE: begin
                    q[0] = dg;
                    q[1] = half_ratio(m[5] - m[7], h);
                    q[2] = half_ratio(m[6] - m[2], h);
                    q[3] = half_ratio(m[1] - m[3], h);
                end
                BR_X: begin
                    q[0] = half_ratio(m[5] - m[7], h);
                    q[1] = dg;
                    q[2] = half_ratio(m[3] + m[1], h);
                    q[3] = half_ratio(m[6] + m[2], h);
                end
                BR_Y: begin
                    q[0] = half_ratio(m[6] - m[2], h);
                    q[1] = half_ratio(m[3] + m[1], h);
                    q[2] = dg;
                    q[3] = half_ratio(m[7] + m[5], h);
                end
                default: begin
                    q[0] = half_ratio(m[1] - m[3], h);
                    q[1] = half_ratio(m[6] + m[2], h);
                    q[2] = half_ratio(m[7] + m[5], h);
                    q[3] = dg;
                end
            endcase
        end
        res.w = clamp(q[0], deg);
        res.x = clamp(q[1], deg);
        res.y = clamp(q[2], deg);
        res.z = clamp(q[3], deg);
        res.deg = deg;
        return res;
    endfunction

    // valid stays high between back-to-back requests, drops only while idling
    task automatic send_matrix();
        logic [IN_W-1:0] d = '0;
        for (int i = 0; i < 9; i++) d[i*EW +: EW] = mat[i][EW-1:0];
        while (!calm && $urandom_range(99) < 26) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        quat_expected.push_back(quat_from_matrix(mat));
    endtask

    // request checker
    always @(posedge i_clk) begin
        t_quat got;
        t_quat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[0 +: EW], o_m_tdata[EW +: EW], o_m_tdata[2*EW +: EW],
                   o_m_tdata[3*EW +: EW], t_branch'(o_m_tuser[1:0]), o_m_tuser[2]};
            if (quat_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = quat_expected.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp w%h x%h y%h z%h br%0d dg%b  got w%h x%h y%h z%h br%0d dg%b",
                            want.w, want.x, want.y, want.z, want.br, want.deg,
                            got.w, got.x, got.y, got.z, got.br, got.deg);
                end
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= 26);
    end

    function automatic longint rnd_elem();
        return longint'($signed(16'($urandom())));
    endfunction

    task automatic set_mat(longint a0, a1, a2, a3, a4, a5, a6, a7, a8);
        mat = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        send_matrix();
    endtask

    task automatic test_directed();
        set_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);             // identity
        set_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);           // 180 about x
        set_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);           // 180 about y
        set_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);           // 180 about z
        set_mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384);            // 90 about z
        set_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);                         // zero, ties to z
        set_mat(-100, 0, 0, 0, -100, 0, 0, 0, -100);                // ties, z branch
        set_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        set_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        set_mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
        set_mat(32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
        set_mat(-16384, 32767, -32768, -32768, 16384, 32767, 32767, -32768, -16384);
        set_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);          // ties at the minimum, z branch
        set_mat(-8192, 0, 0, 0, -8192, 0, 0, 0, -8192);             // ties at -0.5, z branch
        set_mat(1, 0, 0, 0, 0, 0, 0, 0, 0);                         // trace just positive
        set_mat(0, 5, 7, 0, 0, 32767, -32768, 0, -1);               // trace just negative, y branch
        set_mat(-16383, 32767, 0, -32768, -16383, 0, 0, 0, 16384);
    endtask

    task automatic test_random(int count);
        int    kind;
        real   a, b, c, d, n;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                // near-rotation from a random quaternion plus small noise
                a = $urandom_range(2000) - 1000.0; b = $urandom_range(2000) - 1000.0;
                c = $urandom_range(2000) - 1000.0; d = $urandom_range(2000) - 1000.0;
                n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
                a = a / n; b = b / n; c = c / n; d = d / n;
                mat[0] = longint'(16384.0 * (1 - 2*(c*c + d*d)));
                mat[4] = longint'(16384.0 * (1 - 2*(b*b + d*d)));
                mat[8] = longint'(16384.0 * (1 - 2*(b*b + c*c)));
                mat[1] = longint'(16384.0 * 2*(b*c + a*d));
                mat[3] = longint'(16384.0 * 2*(b*c - a*d));
                mat[2] = longint'(16384.0 * 2*(b*d - a*c));
                mat[6] = longint'(16384.0 * 2*(b*d + a*c));
                mat[5] = longint'(16384.0 * 2*(c*d + a*b));
                mat[7] = longint'(16384.0 * 2*(c*d - a*b));
                for (int i = 0; i < 9; i++) mat[i] += longint'($urandom_range(8)) - 4;
            end else begin
                for (int i = 0; i < 9; i++) mat[i] = rnd_elem();
            end
            send_matrix();
        end
    endtask

    initial begin
        int waited = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        calm = 1'b1;
        test_random(300);
        calm = 1'b0;
        test_random(700);
        i_s_tvalid <= 1'b0;
        while (quat_expected.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && quat_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/rm2q_pkg.sv
sv/rotation_matrix_to_quaternion.sv
sv/rm2q_checker.sv
tb/rotation_matrix_to_quaternion_tb.sv
